// ===== hw/rtl/sgcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Sphere ground contact force: shared constants
// Register indexes, reset values, saturation bounds and the coefficients of
// the quarter-wave sine polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

package sgcf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_GROUND_LEVEL       = 3'd0;
  localparam logic [2:0] REG_GROUND_STIFFNESS   = 3'd1;
  localparam logic [2:0] REG_FRICTION_COEFF     = 3'd2;
  localparam logic [2:0] REG_DAMPING_RATIO      = 3'd3;
  localparam logic [2:0] REG_FRICTION_REG_SPEED = 3'd4;

  // Register reset values.
  localparam logic [31:0] RST_GROUND_LEVEL       = 32'd0;
  localparam logic [47:0] RST_GROUND_STIFFNESS   = 48'd196608000000;
  localparam logic [31:0] RST_FRICTION_COEFF     = 32'd19661;
  localparam logic [31:0] RST_DAMPING_RATIO      = 32'd65536;
  localparam logic [31:0] RST_FRICTION_REG_SPEED = 32'd655;

  // Saturation bound on intermediate magnitudes (2^62).
  localparam logic [62:0] CAP = 63'h4000_0000_0000_0000;

  // Output range, signed Q32.16.
  localparam logic [47:0] F48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] F48_MIN = 48'h8000_0000_0000;
  localparam logic signed [63:0] F48_MAX_S64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] F48_MIN_S64 = 64'shFFFF_8000_0000_0000;
  localparam logic [62:0] MAG_POS_LIM = 63'h0000_7FFF_FFFF_FFFF;
  localparam logic [62:0] MAG_NEG_LIM = 63'h0000_8000_0000_0000;

  // Q30 odd polynomial for sin(pi/2 * x).
  localparam logic [30:0] SC1 = 31'd1686629713;
  localparam logic [30:0] SC3 = 31'd693598668;
  localparam logic [30:0] SC5 = 31'd85569306;
  localparam logic [30:0] SC7 = 31'd5026995;
  localparam logic [30:0] SC9 = 31'd172272;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

endpackage

`default_nettype wire

// ===== hw/rtl/sphere_ground_contact_force_core.sv =====
// ----------------------------------------------------------------------------
// Sphere ground contact force core
// Spring-dashpot normal force and regularized sine friction for one sphere
// per transaction, Q16.16 inputs, saturated Q32.16 forces.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      sink       in_valid/in_ready  centre_z, sphere_radius, body_mass,
//                                         vel_x, vel_y, vel_z
//  out_     source     out_valid/out_ready in_contact, force_x/y/z
//  cfg_     sink       cfg_we             cfg_index, cfg_wdata
//
// One transaction is accepted per cycle while the output is not stalled. The
// pipeline depth is set by the 47-stage square root of k_eff * mass followed
// by the damping, normal and friction multiply stages.
// Reset clears the valid bits and loads the register reset values.
// When the output holds a result that is not taken, the whole pipeline
// freezes and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_ground_contact_force_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_centre_z,
  input  logic [30:0] in_sphere_radius,
  input  logic [31:0] in_body_mass,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_in_contact,
  output logic [47:0] out_force_x,
  output logic [47:0] out_force_y,
  output logic [47:0] out_force_z
);

  localparam int NST      = 61;
  localparam int FLG_DLY  = 59;
  localparam int VZP_DLY  = 52;
  localparam int AX_DLY   = 35;
  localparam int SPR_DLY  = 51;
  localparam int FN_DLY   = 4;

  // Configuration registers.
  logic [31:0] gl_r;
  logic [47:0] stiff_r;
  logic [31:0] fc_r;
  logic [31:0] dr_r;
  logic [31:0] frs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gl_r    <= sgcf_pkg::RST_GROUND_LEVEL;
      stiff_r <= sgcf_pkg::RST_GROUND_STIFFNESS;
      fc_r    <= sgcf_pkg::RST_FRICTION_COEFF;
      dr_r    <= sgcf_pkg::RST_DAMPING_RATIO;
      frs_r   <= sgcf_pkg::RST_FRICTION_REG_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        sgcf_pkg::REG_GROUND_LEVEL:       gl_r    <= cfg_wdata[31:0];
        sgcf_pkg::REG_GROUND_STIFFNESS:   stiff_r <= cfg_wdata;
        sgcf_pkg::REG_FRICTION_COEFF:     fc_r    <= cfg_wdata[31:0];
        sgcf_pkg::REG_DAMPING_RATIO:      dr_r    <= cfg_wdata[31:0];
        sgcf_pkg::REG_FRICTION_REG_SPEED: frs_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a single advance enable for every stage.
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv       = !vld_r[NST-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Stage 1: penetration, stiffness partial products, speed magnitudes.
  logic [33:0] pen_w;
  logic        contact_w;
  logic [31:0] vel_w [2];

  assign pen_w = {{2{gl_r[31]}}, gl_r} - {{2{in_centre_z[31]}}, in_centre_z}
               + {3'b000, in_sphere_radius};
  assign contact_w = !pen_w[33] && (pen_w != '0);
  assign vel_w[0]  = in_vel_x;
  assign vel_w[1]  = in_vel_y;

  logic [32:0] pen_s1_r;
  logic [31:0] m_s1_r;
  logic [62:0] kp0_s1_r;
  logic [46:0] kp1_s1_r;
  logic [30:0] vzp_s1_r;
  logic [31:0] ax_s1_r [2];
  logic [2:0]  flg_s1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pen_s1_r <= pen_w[32:0];
      m_s1_r   <= in_body_mass;
      kp0_s1_r <= 63'(stiff_r[31:0]) * 63'(in_sphere_radius);
      kp1_s1_r <= 47'(stiff_r[47:32]) * 47'(in_sphere_radius);
      vzp_s1_r <= (!in_vel_z[31] && (in_vel_z != '0)) ? in_vel_z[30:0] : '0;
      flg_s1_r <= {contact_w, in_vel_x[31], in_vel_y[31]};
      for (int l = 0; l < 2; l++) begin
        ax_s1_r[l] <= vel_w[l][31] ? 32'd0 - vel_w[l] : vel_w[l];
      end
    end
  end

  // Stage 2: k_eff, squared speeds.
  logic [78:0] ksum_w;
  logic [62:0] ksh_w;

  assign ksum_w = 79'(kp0_s1_r) + {kp1_s1_r, 32'd0};
  assign ksh_w  = ksum_w[78:16];

  logic [62:0] keff_s2_r;
  logic [32:0] pen_s2_r;
  logic [31:0] m_s2_r;
  logic [63:0] sq_s2_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      keff_s2_r <= (ksh_w > sgcf_pkg::CAP) ? sgcf_pkg::CAP : ksh_w;
      pen_s2_r  <= pen_s1_r;
      m_s2_r    <= m_s1_r;
      for (int l = 0; l < 2; l++) begin
        sq_s2_r[l] <= 64'(ax_s1_r[l]) * 64'(ax_s1_r[l]);
      end
    end
  end

  // Stage 3: spring and k_eff * mass partial products, horizontal speed sum.
  logic [64:0] q0_s3_r;
  logic [63:0] q1_s3_r;
  logic [63:0] mp0_s3_r;
  logic [62:0] mp1_s3_r;
  logic [63:0] hsum_s3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      q0_s3_r   <= 65'(keff_s2_r[31:0]) * 65'(pen_s2_r);
      q1_s3_r   <= 64'(keff_s2_r[62:32]) * 64'(pen_s2_r);
      mp0_s3_r  <= 64'(keff_s2_r[31:0]) * 64'(m_s2_r);
      mp1_s3_r  <= 63'(keff_s2_r[62:32]) * 63'(m_s2_r);
      hsum_s3_r <= sq_s2_r[0] + sq_s2_r[1];
    end
  end

  // Stage 4: spring force and the radicand of the damping root.
  logic [95:0] ssum_w;
  logic [79:0] ssh_w;
  logic [94:0] rsum_w;

  assign ssum_w = 96'(q0_s3_r) + {q1_s3_r, 32'd0};
  assign ssh_w  = ssum_w[95:16];
  assign rsum_w = 95'(mp0_s3_r) + {mp1_s3_r, 32'd0};

  logic [62:0] spring_s4_r;
  logic [93:0] rad_s4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      spring_s4_r <= (ssh_w > 80'(sgcf_pkg::CAP)) ? sgcf_pkg::CAP : ssh_w[62:0];
      rad_s4_r    <= rsum_w[93:0];
    end
  end

  // Square roots: sqrt(k_eff * mass) lands at stage 51, |v_h| at stage 35.
  logic [46:0] root_w;
  logic [31:0] vh_w;

  sgcf_isqrt_pipe #(.W(94)) u_root_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  (rad_s4_r),
    .root_o (root_w)
  );

  sgcf_isqrt_pipe #(.W(64)) u_vh_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_i  (hsum_s3_r),
    .root_o (vh_w)
  );

  // Delay lines that carry side data to the stage that needs it.
  logic [2:0]  flg_dl_r    [FLG_DLY];
  logic [30:0] vzp_dl_r    [VZP_DLY];
  logic [31:0] ax_dl_r     [2][AX_DLY];
  logic [62:0] spring_dl_r [SPR_DLY];
  logic [47:0] fn_dl_r     [FN_DLY];
  logic [47:0] fn_s56_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      flg_dl_r[0]    <= flg_s1_r;
      vzp_dl_r[0]    <= vzp_s1_r;
      spring_dl_r[0] <= spring_s4_r;
      fn_dl_r[0]     <= fn_s56_r;
      for (int j = 1; j < FLG_DLY; j++) flg_dl_r[j] <= flg_dl_r[j-1];
      for (int j = 1; j < VZP_DLY; j++) vzp_dl_r[j] <= vzp_dl_r[j-1];
      for (int j = 1; j < SPR_DLY; j++) spring_dl_r[j] <= spring_dl_r[j-1];
      for (int j = 1; j < FN_DLY; j++) fn_dl_r[j] <= fn_dl_r[j-1];
      for (int l = 0; l < 2; l++) begin
        ax_dl_r[l][0] <= ax_s1_r[l];
        for (int j = 1; j < AX_DLY; j++) ax_dl_r[l][j] <= ax_dl_r[l][j-1];
      end
    end
  end

  // Stage 36: friction divisor.
  logic [31:0] dmax_w;
  logic [31:0] den_s36_r;

  assign dmax_w = (frs_r > vh_w) ? frs_r : vh_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_s36_r <= (dmax_w == '0) ? 32'd1 : dmax_w;
    end
  end

  // Stages 37..53: speed ratio |v| / den per axis, in Q16.
  logic [16:0] ratio_w [2];

  genvar g;
  for (g = 0; g < 2; g++) begin : g_lane_div
    sgcf_div_pipe #(.NW(48), .DW(32), .QW(17)) u_div (
      .clk   (clk),
      .en    (adv),
      .num_i ({ax_dl_r[g][AX_DLY-1], 16'd0}),
      .den_i (den_s36_r),
      .quo_o (ratio_w[g])
    );
  end

  // Stages 52..53: damping coefficient.
  logic [63:0] cp0_s52_r;
  logic [46:0] cp1_s52_r;
  logic [78:0] csum_w;
  logic [63:0] csh_w;
  logic [62:0] ceff_s53_r;

  assign csum_w = 79'(cp0_s52_r) + {cp1_s52_r, 32'd0};
  assign csh_w  = csum_w[78:15];

  always_ff @(posedge clk) begin
    if (adv) begin
      cp0_s52_r  <= 64'(dr_r) * 64'(root_w[31:0]);
      cp1_s52_r  <= 47'(dr_r) * 47'(root_w[46:32]);
      ceff_s53_r <= (csh_w > 64'(sgcf_pkg::CAP)) ? sgcf_pkg::CAP : csh_w[62:0];
    end
  end

  // Stages 54..55: damping force.
  logic [62:0] dp0_s54_r;
  logic [61:0] dp1_s54_r;
  logic [93:0] dsum_w;
  logic [77:0] dsh_w;
  logic [62:0] damp_s55_r;

  assign dsum_w = 94'(dp0_s54_r) + {dp1_s54_r, 32'd0};
  assign dsh_w  = dsum_w[93:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      dp0_s54_r  <= 63'(ceff_s53_r[31:0]) * 63'(vzp_dl_r[VZP_DLY-1]);
      dp1_s54_r  <= 62'(ceff_s53_r[62:32]) * 62'(vzp_dl_r[VZP_DLY-1]);
      damp_s55_r <= (dsh_w > 78'(sgcf_pkg::CAP)) ? sgcf_pkg::CAP : dsh_w[62:0];
    end
  end

  // Stage 56: normal force, saturated to the output range.
  logic signed [63:0] diff_w;

  assign diff_w = signed'(64'(spring_dl_r[SPR_DLY-1])) - signed'(64'(damp_s55_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (diff_w > sgcf_pkg::F48_MAX_S64) begin
        fn_s56_r <= sgcf_pkg::F48_MAX;
      end else if (diff_w < sgcf_pkg::F48_MIN_S64) begin
        fn_s56_r <= sgcf_pkg::F48_MIN;
      end else begin
        fn_s56_r <= diff_w[47:0];
      end
    end
  end

  // Stages 57..59: friction magnitude mu * |Fn|.
  logic [47:0] afn_w;
  logic [63:0] fp0_s57_r;
  logic [47:0] fp1_s57_r;
  logic [79:0] fsum_w;
  logic [63:0] fsh_w;
  logic [62:0] fmag_s58_r;
  logic [62:0] fmag_s59_r;

  assign afn_w  = fn_s56_r[47] ? 48'd0 - fn_s56_r : fn_s56_r;
  assign fsum_w = 80'(fp0_s57_r) + {fp1_s57_r, 32'd0};
  assign fsh_w  = fsum_w[79:16];

  always_ff @(posedge clk) begin
    if (adv) begin
      fp0_s57_r  <= 64'(fc_r) * 64'(afn_w[31:0]);
      fp1_s57_r  <= 48'(fc_r) * 48'(afn_w[47:32]);
      fmag_s58_r <= (fsh_w > 64'(sgcf_pkg::CAP)) ? sgcf_pkg::CAP : fsh_w[62:0];
      fmag_s59_r <= fmag_s58_r;
    end
  end

  // Stages 54..59: sine polynomial per axis, one Horner step per stage.
  logic [30:0] xc_r  [2][5];
  logic [30:0] x2c_r [2][4];
  logic [30:0] hp_r  [2][4];
  logic [30:0] sine_s59_r [2];
  logic [30:0] hc_w [4];

  assign hc_w[0] = sgcf_pkg::SC7;
  assign hc_w[1] = sgcf_pkg::SC5;
  assign hc_w[2] = sgcf_pkg::SC3;
  assign hc_w[3] = sgcf_pkg::SC1;

  logic [30:0] x_w    [2];
  logic [61:0] xx_w   [2];
  logic [61:0] hprod_w [2][4];
  logic [31:0] hnxt_w  [2][4];
  logic [61:0] sprod_w [2];
  logic [31:0] sv_w    [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      x_w[l]  = {ratio_w[l], 14'd0};
      xx_w[l] = 62'(x_w[l]) * 62'(x_w[l]);
      hprod_w[l][0] = 62'(x2c_r[l][0]) * 62'(sgcf_pkg::SC9);
      for (int j = 1; j < 4; j++) begin
        hprod_w[l][j] = 62'(x2c_r[l][j]) * 62'(hp_r[l][j-1]);
      end
      for (int j = 0; j < 4; j++) begin
        hnxt_w[l][j] = 32'(hc_w[j]) - hprod_w[l][j][61:30];
      end
      sprod_w[l] = 62'(xc_r[l][4]) * 62'(hp_r[l][3]);
      sv_w[l]    = sprod_w[l][61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        xc_r[l][0]  <= x_w[l];
        x2c_r[l][0] <= xx_w[l][60:30];
        for (int j = 1; j < 5; j++) xc_r[l][j] <= xc_r[l][j-1];
        for (int j = 1; j < 4; j++) x2c_r[l][j] <= x2c_r[l][j-1];
        for (int j = 0; j < 4; j++) hp_r[l][j] <= hnxt_w[l][j][30:0];
        sine_s59_r[l] <= (sv_w[l] > 32'(sgcf_pkg::ONE_Q30)) ? sgcf_pkg::ONE_Q30
                                                           : sv_w[l][30:0];
      end
    end
  end

  // Stage 60: friction partial products.
  logic [62:0] mp0_s60_r [2];
  logic [61:0] mp1_s60_r [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        mp0_s60_r[l] <= 63'(fmag_s59_r[31:0]) * 63'(sine_s59_r[l]);
        mp1_s60_r[l] <= 62'(fmag_s59_r[62:32]) * 62'(sine_s59_r[l]);
      end
    end
  end

  // Stage 61: signed, saturated friction and the output register.
  logic [2:0]  flg_w;
  logic [47:0] fn_w;
  logic [93:0] msum_w [2];
  logic [63:0] msh_w  [2];
  logic [62:0] mm_w   [2];
  logic        neg_w  [2];
  logic [47:0] fr_w   [2];

  assign flg_w = flg_dl_r[FLG_DLY-1];
  assign fn_w  = fn_dl_r[FN_DLY-1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      msum_w[l] = 94'(mp0_s60_r[l]) + {mp1_s60_r[l], 32'd0};
      msh_w[l]  = msum_w[l][93:30];
      mm_w[l]   = (msh_w[l] > 64'(sgcf_pkg::CAP)) ? sgcf_pkg::CAP : msh_w[l][62:0];
      // Friction opposes the velocity when Fn is positive.
      neg_w[l]  = fn_w[47] == flg_w[1-l];
      if (neg_w[l]) begin
        fr_w[l] = (mm_w[l] > sgcf_pkg::MAG_NEG_LIM) ? sgcf_pkg::F48_MIN
                                                    : 48'd0 - mm_w[l][47:0];
      end else begin
        fr_w[l] = (mm_w[l] > sgcf_pkg::MAG_POS_LIM) ? sgcf_pkg::F48_MAX
                                                    : mm_w[l][47:0];
      end
    end
  end

  logic        out_contact_r;
  logic [47:0] out_fx_r;
  logic [47:0] out_fy_r;
  logic [47:0] out_fz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_contact_r <= flg_w[2];
      out_fx_r      <= flg_w[2] ? fr_w[0] : '0;
      out_fy_r      <= flg_w[2] ? fr_w[1] : '0;
      out_fz_r      <= flg_w[2] ? fn_w : '0;
    end
  end

  assign out_in_contact = out_contact_r;
  assign out_force_x    = out_fx_r;
  assign out_force_y    = out_fy_r;
  assign out_force_z    = out_fz_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sgcf_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit restoring square root, one result bit per register stage.
// The whole pipeline advances when en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sgcf_isqrt_pipe #(
  parameter int W = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     rad_i,
  output logic [W/2-1:0]   root_o
);

  localparam int H  = W / 2;
  localparam int RW = H + 1;

  logic [W-1:0]  rad_r  [H];
  logic [RW-1:0] rem_r  [H];
  logic [H-1:0]  root_r [H];

  genvar k;
  for (k = 0; k < H; k++) begin : g_stage
    logic [W-1:0]  rad_in;
    logic [RW-1:0] rem_in;
    logic [H-1:0]  root_in;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign cur   = {rem_in, rad_in[W-1:W-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_in << 2;
        if (cur >= trial) begin
          rem_r[k]  <= diff[RW-1:0];
          root_r[k] <= {root_in[H-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cur[RW-1:0];
          root_r[k] <= {root_in[H-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_r[H-1];

endmodule

`default_nettype wire

// ===== hw/rtl/sgcf_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The numerator must
// be below the divisor times 2^QW so that QW quotient bits are enough.
// ----------------------------------------------------------------------------
`default_nettype none

module sgcf_div_pipe #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {{(NW + 1 - DW){1'b0}}, den_in} << (QW - 1 - k);
    assign ge    = {1'b0, rem_in} >= trial;
    assign diff  = {1'b0, rem_in} - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        quo_r[k] <= {quo_in[QW-2:0], ge};
        rem_r[k] <= ge ? diff[NW-1:0] : rem_in;
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

`default_nettype wire
